// ===== hw/rtl/ssm_pkg.sv =====
// ----------------------------------------------------------------------------
// ssm_pkg: shared types, constants and table math for the tone mixer
// Holds the sample format, the mixing amplitudes and the Taylor-series
// sine used to build the quarter-wave table at elaboration.
// ----------------------------------------------------------------------------
`default_nettype none

package ssm_pkg;

    // Default quarter-wave table depth (entries per quarter period)
    localparam int SINE_TABLE_DEPTH_DEF = 1024;

    // Field widths
    localparam int PHASE_W  = 32;
    localparam int TIME_W   = 32;
    localparam int SAMPLE_W = 14;
    localparam int MAG_W    = 12;   // table entries are 0..3500

    // Amplitudes and fixed-point constants
    localparam logic [63:0] SINE_AMP    = 64'd3500;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1073741824;

    localparam logic signed [SAMPLE_W-1:0] SQUARE_POS = 14'sd1500;
    localparam logic signed [SAMPLE_W-1:0] SQUARE_NEG = -14'sd1500;

    // Bounds of the sample value: 3500 sine peak plus 1500 square
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 14'sd5000;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = -14'sd5000;

    // Table entry: floor(3500 * sin(x)), x in Q2.30, sine by an
    // odd-power Taylor series up to x^15 with each term truncated.
    function automatic logic [MAG_W-1:0] quarter_entry(input logic [63:0] x);
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        scaled;
        x2   = (x * x) >> 30;
        term = x;
        sum  = $signed(x);
        term = ((term * x2) >> 30) / 64'd6;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd42;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd110;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd156;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd210;
        sum  = sum - $signed(term);
        // clamp to [0, 1.0]
        if (sum < 0) begin
            sum = 64'sd0;
        end
        if (sum > $signed(ONE_Q30)) begin
            sum = $signed(ONE_Q30);
        end
        scaled = (SINE_AMP * $unsigned(sum)) >> 30;
        return scaled[MAG_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/sine_square_tone_mixer.sv =====
// ----------------------------------------------------------------------------
// sine_square_tone_mixer: DDS tone generator with sine and square mix
// One audio sample per input transaction from a running sample counter.
// ----------------------------------------------------------------------------
// Each accepted transaction yields one sample, and a new transaction can be
// accepted every cycle while the output is not stalled. Five register stages
// carry it: input register, phase (low 32 bits of phase_increment times the
// sample counter, one 32x32 multiply), table address, quarter-wave ROM read
// and final mix. The output is 3500*sin(phase) plus 1500 when the sine is
// positive, minus 1500 otherwise, and 0 when the increment is zero (a rest).
// restart clears the counter before its own sample; the counter advances on
// every transaction. Stages with no data accept new work even while the output
// is stalled, so up to five transactions can be held.
`default_nettype none

module sine_square_tone_mixer #(
    parameter int SINE_TABLE_DEPTH = ssm_pkg::SINE_TABLE_DEPTH_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // input channel
    input  wire logic                                  i_valid,
    output logic                                       o_ready,
    input  wire logic [ssm_pkg::PHASE_W-1:0]           i_phase_increment,
    input  wire logic                                  i_restart,
    // output channel
    output logic                                       o_valid,
    input  wire logic                                  i_ready,
    output logic signed [ssm_pkg::SAMPLE_W-1:0]        o_sample
);

    localparam int ADDR_W = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int PROD_W = 30 + ADDR_W;
    localparam int NSTAGE = 5;

    // Stage valids and enables
    logic [NSTAGE-1:0] r_v;
    logic [NSTAGE:0]   w_en;
    logic              w_acc;

    // Sample counter
    logic [ssm_pkg::TIME_W-1:0]  r_time;
    logic [ssm_pkg::TIME_W-1:0]  w_time_used;

    // Stage 0: input register
    logic [ssm_pkg::PHASE_W-1:0] r_inc0;
    logic [ssm_pkg::TIME_W-1:0]  r_time0;

    // Stage 1: phase
    logic [ssm_pkg::PHASE_W-1:0] r_phase1;
    logic                        r_rest1;
    logic [ssm_pkg::PHASE_W-1:0] w_mul;

    // Stage 2: table address and sign flags
    logic [PROD_W-1:0]           w_prod;
    logic [ADDR_W-1:0]           w_idx;
    logic [1:0]                  w_quad;
    logic [ADDR_W-1:0]           r_addr2;
    logic                        r_pos2;
    logic                        r_neg2;
    logic                        r_rest2;

    // Stage 3: table data and flags
    logic [ssm_pkg::MAG_W-1:0]   w_mag3;
    logic                        r_pos3;
    logic                        r_neg3;
    logic                        r_rest3;

    // Stage 4: output sample
    logic signed [ssm_pkg::SAMPLE_W-1:0] w_smag;
    logic signed [ssm_pkg::SAMPLE_W-1:0] n_sample;
    logic signed [ssm_pkg::SAMPLE_W-1:0] r_sample;

    // Per-stage enables: a stage loads when empty or when the next one moves
    always_comb begin
        w_en[NSTAGE] = i_ready;
        for (int k = NSTAGE - 1; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    assign o_ready = w_en[0];
    assign w_acc   = i_valid && w_en[0];
    assign o_valid = r_v[NSTAGE-1];

    // Valid pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < NSTAGE; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // Sample counter: restart clears it before this sample
    assign w_time_used = i_restart ? '0 : r_time;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time <= '0;
        end else if (w_acc) begin
            r_time <= w_time_used + 32'd1;
        end
    end

    // Stage 0 capture
    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_inc0  <= i_phase_increment;
            r_time0 <= w_time_used;
        end
    end

    // Stage 1: phase = low 32 bits of increment * time
    assign w_mul = r_inc0 * r_time0;

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_phase1 <= w_mul;
            r_rest1  <= (r_inc0 == '0);
        end
    end

    // Stage 2: quadrant, table index, mirrored address
    assign w_quad = r_phase1[31:30];
    assign w_prod = PROD_W'(r_phase1[29:0]) * PROD_W'(SINE_TABLE_DEPTH);
    assign w_idx  = w_prod[30 +: ADDR_W];

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r_addr2 <= w_quad[0] ? (ADDR_W'(SINE_TABLE_DEPTH) - w_idx) : w_idx;
            r_pos2  <= (w_quad == 2'd0) ? (w_idx != '0) : (w_quad == 2'd1);
            r_neg2  <= w_quad[1];
            r_rest2 <= r_rest1;
        end
    end

    // Stage 3: table read
    ssm_quarter_rom #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_rom (
        .i_clk  (i_clk),
        .i_en   (w_en[3]),
        .i_addr (r_addr2),
        .o_data (w_mag3)
    );

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r_pos3  <= r_pos2;
            r_neg3  <= r_neg2;
            r_rest3 <= r_rest2;
        end
    end

    // Stage 4: sign the sine, add the square, zero on rest
    always_comb begin
        w_smag = $signed({2'b00, w_mag3});
        if (r_neg3) begin
            w_smag = -w_smag;
        end
        n_sample = w_smag + (r_pos3 ? ssm_pkg::SQUARE_POS : ssm_pkg::SQUARE_NEG);
        if (r_rest3) begin
            n_sample = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r_sample <= n_sample;
        end
    end

    assign o_sample = r_sample;

`ifndef SYNTHESIS
    // Counter restarts at one after a restart transaction
    a_restart_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_restart) |=> (r_time == 32'd1))
        else $error("sample counter not restarted");

    // Counter advances by one on a plain transaction
    a_time_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && !i_restart) |=> (r_time == $past(r_time) + 32'd1))
        else $error("sample counter did not advance");

    // Table address stays within the quarter table
    a_addr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[2] |-> (r_addr2 <= ADDR_W'(SINE_TABLE_DEPTH)))
        else $error("table address out of range");

    // Sample range
    a_sample_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_sample >= ssm_pkg::SAMPLE_MIN) && (o_sample <= ssm_pkg::SAMPLE_MAX)))
        else $error("sample out of range");

    // Square part keeps non-rest samples at least 1500 away from zero
    a_sample_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_sample == '0) || (o_sample >= ssm_pkg::SQUARE_POS)
                     || (o_sample <= ssm_pkg::SQUARE_NEG)))
        else $error("sample inside the square gap");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/ssm_quarter_rom.sv =====
// ----------------------------------------------------------------------------
// ssm_quarter_rom: quarter-wave sine magnitude ROM
// DEPTH+1 entries of 3500*sin(pi/2*k/DEPTH), built at elaboration, with a
// registered read port that holds its data while the read enable is low.
// ----------------------------------------------------------------------------
`default_nettype none

module ssm_quarter_rom #(
    parameter int SINE_TABLE_DEPTH = ssm_pkg::SINE_TABLE_DEPTH_DEF,
    localparam int ADDR_W = $clog2(SINE_TABLE_DEPTH + 1)
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_en,
    input  wire logic [ADDR_W-1:0]          i_addr,
    output logic      [ssm_pkg::MAG_W-1:0]  o_data
);

    logic [ssm_pkg::MAG_W-1:0] w_rom [0:SINE_TABLE_DEPTH];
    logic [ssm_pkg::MAG_W-1:0] r_data;

    // Constant table contents
    for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_entry
        localparam logic [63:0] ARG =
            (ssm_pkg::HALF_PI_Q30 * 64'(k)) / 64'(SINE_TABLE_DEPTH);
        assign w_rom[k] = ssm_pkg::quarter_entry(ARG);
    end

    // Registered read
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= w_rom[i_addr];
        end
    end

    assign o_data = r_data;

endmodule

`default_nettype wire
